@@ rtl/bump_map_normal_perturb_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the bump map normal perturbation core
// Implication checks, empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef BUMP_MAP_NORMAL_PERTURB_CORE_MACROS_SVH
`define BUMP_MAP_NORMAL_PERTURB_CORE_MACROS_SVH
`ifndef SYNTH
`define BMNP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bmnp assertion failed");
`define BMNP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bmnp assertion failed");
`else
`define BMNP_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define BMNP_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ rtl/bmnp_pkg.sv @@
// ---------------------------------------------------------------------------
// bmnp_pkg
// Shared types and constants of the bump map normal perturbation core.
// ---------------------------------------------------------------------------
package bmnp_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // size compare width, enough for the largest map dimension
  localparam int SZW = 13;
  // queue address width, enough for the largest map
  localparam int AMW = 24;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BUMP_GAIN  = 2'd2;

  localparam logic [8:0] RST_MAP_WIDTH  = 9'd256;
  localparam logic [8:0] RST_MAP_HEIGHT = 9'd256;
  localparam logic [7:0] RST_BUMP_GAIN  = 8'd20;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NZ_ZERO = 2'd1;
  localparam logic [1:0] ST_DEGEN   = 2'd2;

  typedef logic signed [34:0] vec_t;
  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    logic [8:0] map_width;
    logic [8:0] map_height;
    logic [7:0] bump_gain;
  } cfg_t;

  // one queued item; a load uses ad0 as its write address
  typedef struct packed {
    logic           cmd;
    logic           ld_ok;
    logic [7:0]     red;
    q14_t           nx;
    q14_t           ny;
    q14_t           nz;
    logic           nz0;
    logic [AMW-1:0] ad0;
    logic [AMW-1:0] ad1;
    logic [AMW-1:0] ad2;
  } qent_t;

  typedef struct packed {
    logic start;
    vec_t v0;
    vec_t v1;
    vec_t v2;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic ok;
    q14_t u0;
    q14_t u1;
    q14_t u2;
  } unit_rsp_t;

endpackage

@@ rtl/bmnp_front.sv @@
// ---------------------------------------------------------------------------
// bmnp_front
// Accepts beats, scales and clamps coordinates, forms texel addresses.
// ---------------------------------------------------------------------------
module bmnp_front #(
  parameter int MAX_WIDTH  = bmnp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmnp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bmnp_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [7:0]            in_tx,
  input  logic [7:0]            in_ty,
  input  logic [7:0]            in_red,
  input  logic signed [15:0]    in_nx,
  input  logic signed [15:0]    in_ny,
  input  logic signed [15:0]    in_nz,
  input  logic signed [17:0]    in_u,
  input  logic signed [17:0]    in_v,
  output logic                  push,
  input  logic                  push_ready,
  output bmnp_pkg::qent_t       push_ent
);
  import bmnp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic              vld;
  logic              cmd;
  logic [7:0]        tx, ty, red;
  q14_t              nx, ny, nz;
  logic signed [31:0] pu, pv;
  logic [SZW-1:0]    w, h;

  logic [SZW-1:0] w_in, h_in;
  logic [SZW-1:0] x, y, x1, y1, kx, ky;

  always_comb begin
    if (cfg.map_width == 9'd0) w_in = SZW'(1);
    else if (SZW'(cfg.map_width) > SZW'(MAX_WIDTH)) w_in = SZW'(MAX_WIDTH);
    else w_in = SZW'(cfg.map_width);
    if (cfg.map_height == 9'd0) h_in = SZW'(1);
    else if (SZW'(cfg.map_height) > SZW'(MAX_HEIGHT)) h_in = SZW'(MAX_HEIGHT);
    else h_in = SZW'(cfg.map_height);
  end

  assign in_ready = !vld || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
    if (in_valid && in_ready) begin
      cmd <= in_cmd;
      tx  <= in_tx;
      ty  <= in_ty;
      red <= in_red;
      nx  <= in_nx;
      ny  <= in_ny;
      nz  <= in_nz;
      pu  <= in_u * $signed({1'b0, w_in});
      pv  <= in_v * $signed({1'b0, h_in});
      w   <= w_in;
      h   <= h_in;
    end
  end

  // floor(c*size/2^16) clamped to [0, size-1]
  always_comb begin
    kx = pu[SZW+15:16];
    ky = pv[SZW+15:16];
    if (pu < 0) x = '0;
    else if (pu[31:SZW+16] != '0 || kx > w - SZW'(1)) x = w - SZW'(1);
    else x = kx;
    if (pv < 0) y = '0;
    else if (pv[31:SZW+16] != '0 || ky > h - SZW'(1)) y = h - SZW'(1);
    else y = ky;
    x1 = (x + SZW'(1) < w) ? x + SZW'(1) : w - SZW'(1);
    y1 = (y + SZW'(1) < h) ? y + SZW'(1) : h - SZW'(1);
  end

  always_comb begin
    push = vld;
    push_ent.cmd   = cmd;
    push_ent.ld_ok = (SZW'(tx) < SZW'(MAX_WIDTH)) && (SZW'(ty) < SZW'(MAX_HEIGHT));
    push_ent.red   = red;
    push_ent.nx    = nx;
    push_ent.ny    = ny;
    push_ent.nz    = nz;
    push_ent.nz0   = (nz == 16'sd0);
    if (cmd == CMD_LOAD) begin
      push_ent.ad0 = AMW'(AW'(ty) * AW'(MAX_WIDTH) + AW'(tx));
    end else begin
      push_ent.ad0 = AMW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x));
    end
    push_ent.ad1 = AMW'(AW'(y) * AW'(MAX_WIDTH) + AW'(x1));
    push_ent.ad2 = AMW'(AW'(y1) * AW'(MAX_WIDTH) + AW'(x));
  end

endmodule

@@ rtl/bmnp_fifo.sv @@
// ---------------------------------------------------------------------------
// bmnp_fifo
// Short queue between front and back.
// ---------------------------------------------------------------------------
module bmnp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);
  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wp, rp;
  logic [PW:0]      count;
  logic             do_push, do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign empty      = (count == '0);
  assign head       = slots[rp];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(DEPTH-1)) ? '0 : wp + PW'(1);
      if (do_pop)  rp <= (rp == PW'(DEPTH-1)) ? '0 : rp + PW'(1);
      count <= count + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
    if (do_push) slots[wp] <= push_data;
  end

endmodule

@@ rtl/bmnp_unit.sv @@
// ---------------------------------------------------------------------------
// bmnp_unit
// Iterative normalize: sum of squares, scale, square root, rounded divide.
// ---------------------------------------------------------------------------
module bmnp_unit (
  input  logic                clk,
  input  logic                rst,
  input  bmnp_pkg::unit_req_t req,
  output bmnp_pkg::unit_rsp_t rsp
);
  import bmnp_pkg::*;

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_SQ   = 3'd1;
  localparam logic [2:0] U_CHK  = 3'd2;
  localparam logic [2:0] U_NRM  = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;
  localparam logic [2:0] U_DSET = 3'd5;
  localparam logic [2:0] U_DIV  = 3'd6;
  localparam logic [2:0] U_DFIN = 3'd7;

  logic [2:0]  state;
  logic [34:0] mg [3];
  logic [2:0]  neg;
  logic [1:0]  ci, pi;
  logic [63:0] s, r, b;
  logic [4:0]  m;
  logic [48:0] rem, dsh;
  logic [15:0] q;
  logic [3:0]  k;
  logic        sat;
  q14_t        u [3];

  logic [34:0] cur;
  logic [17:0] ma, mb;
  logic [35:0] prod;
  logic [63:0] prod_sh;
  logic [63:0] num, rb;
  logic [32:0] dd;
  logic [16:0] qq;
  q14_t        uo;

  function automatic logic [34:0] absv(input vec_t v);
    absv = v[34] ? 35'(-v) : 35'(v);
  endfunction

  always_comb begin
    cur = mg[ci];
    case (pi)
      2'd0:    begin ma = cur[17:0];          mb = cur[17:0];          end
      2'd1:    begin ma = {1'b0, cur[34:18]}; mb = cur[17:0];          end
      default: begin ma = {1'b0, cur[34:18]}; mb = {1'b0, cur[34:18]}; end
    endcase
    prod = ma * mb;
    case (pi)
      2'd0:    prod_sh = 64'(prod);
      2'd1:    prod_sh = 64'(prod) << 19;
      default: prod_sh = 64'(prod) << 36;
    endcase
    rb  = r + b;
    dd  = {r[31:0], 1'b0};
    num = ({29'd0, cur} << (6'd15 + 6'(m))) + {32'd0, r[31:0]};
    if (sat || q > 16'd32768) qq = 17'd32768;
    else qq = {1'b0, q};
    if (neg[ci]) uo = 16'(-$signed({1'b0, qq}));
    else if (qq > 17'd32767) uo = 16'sd32767;
    else uo = 16'(qq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      rsp.done <= 1'b0;
      rsp.ok   <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            state <= U_SQ;
          end
        end
        U_SQ: begin
          if (pi == 2'd2 && ci == 2'd2) state <= U_CHK;
        end
        U_CHK: begin
          if (s == '0) begin
            rsp.done <= 1'b1;
            rsp.ok   <= 1'b0;
            state    <= U_IDLE;
          end else begin
            state <= U_NRM;
          end
        end
        U_NRM: begin
          if (s[63:60] != 4'd0) state <= U_SQRT;
        end
        U_SQRT: begin
          if (b == '0) state <= U_DSET;
        end
        U_DSET: state <= U_DIV;
        U_DIV: begin
          if (k == 4'd0) state <= U_DFIN;
        end
        U_DFIN: begin
          if (ci == 2'd2) begin
            rsp.done <= 1'b1;
            rsp.ok   <= 1'b1;
            state    <= U_IDLE;
          end else begin
            state <= U_DSET;
          end
        end
        default: state <= U_IDLE;
      endcase
    end

    case (state)
      U_IDLE: begin
        mg[0] <= absv(req.v0);
        mg[1] <= absv(req.v1);
        mg[2] <= absv(req.v2);
        neg   <= {req.v2[34], req.v1[34], req.v0[34]};
        s     <= '0;
        m     <= '0;
        ci    <= '0;
        pi    <= '0;
      end
      U_SQ: begin
        s <= s + prod_sh;
        if (pi == 2'd2) begin
          pi <= '0;
          ci <= (ci == 2'd2) ? 2'd0 : ci + 2'd1;
        end else begin
          pi <= pi + 2'd1;
        end
      end
      U_NRM: begin
        if (s[63:60] == 4'd0) begin
          s <= s << 2;
          m <= m + 5'd1;
        end else begin
          r <= '0;
          b <= (s[63:62] != 2'd0) ? 64'd1 << 62 : 64'd1 << 60;
        end
      end
      U_SQRT: begin
        if (b != '0) begin
          if (s >= rb) begin
            s <= s - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
        end
      end
      U_DSET: begin
        // quotient of 2^16 or more saturates; else 16 restoring steps
        sat <= (num >= {15'd0, dd, 16'd0});
        rem <= num[48:0];
        dsh <= {1'b0, dd, 15'd0};
        q   <= '0;
        k   <= 4'd15;
      end
      U_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          q   <= {q[14:0], 1'b1};
        end else begin
          q   <= {q[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
        k   <= k - 4'd1;
      end
      U_DFIN: begin
        u[ci] <= uo;
        ci    <= ci + 2'd1;
      end
      default: ;
    endcase
  end

  assign rsp.u0 = u[0];
  assign rsp.u1 = u[1];
  assign rsp.u2 = u[2];

endmodule

@@ rtl/bmnp_back.sv @@
// ---------------------------------------------------------------------------
// bmnp_back
// Texel store, gradient, tangent frame and output register.
// ---------------------------------------------------------------------------
`include "bump_map_normal_perturb_core_macros.svh"
module bmnp_back #(
  parameter int MAX_WIDTH  = bmnp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmnp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          gain,
  input  logic                empty,
  input  bmnp_pkg::qent_t     head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_x,
  output logic signed [15:0]  out_y,
  output logic signed [15:0]  out_z,
  output logic [1:0]          out_status
);
  import bmnp_pkg::*;

  localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_RD   = 4'd1;
  localparam logic [3:0] B_GAIN = 4'd2;
  localparam logic [3:0] B_T1   = 4'd3;
  localparam logic [3:0] B_CRS  = 4'd4;
  localparam logic [3:0] B_T2   = 4'd5;
  localparam logic [3:0] B_VSUM = 4'd6;
  localparam logic [3:0] B_R    = 4'd7;
  localparam logic [3:0] B_DONE = 4'd8;

  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata;

  logic [3:0]  state;
  qent_t       ent;
  logic [2:0]  cnt;
  logic [7:0]  h0, hx;
  logic [16:0] f1, f2;
  q14_t        t1 [3];
  q14_t        t2 [3];
  q14_t        res [3];
  logic [1:0]  st;
  vec_t        acc [3];
  unit_req_t   ureq;
  unit_rsp_t   ursp;

  logic        we;
  logic [AW-1:0] addr;
  logic signed [17:0] ma, mb;
  logic signed [35:0] prod;
  vec_t        base, nxt;
  logic [1:0]  idx;
  logic        first;
  vec_t        acc_next [3];
  vec_t        av0, av1, av2;
  logic signed [17:0] nsum;

  assign pop = (state == B_IDLE) && !empty;
  assign we  = pop && (head.cmd == CMD_LOAD) && head.ld_ok;

  always_comb begin
    if (state == B_IDLE) addr = AW'(head.ad0);
    else if (cnt == 3'd0) addr = AW'(ent.ad0);
    else if (cnt == 3'd1) addr = AW'(ent.ad1);
    else addr = AW'(ent.ad2);
  end

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= head.red;
    rdata <= mem[addr];
  end

  // shared multiplier for the cross product and the final sum
  always_comb begin
    idx   = cnt[2:1];
    first = !cnt[0];
    ma    = '0;
    mb    = '0;
    base  = '0;
    if (state == B_CRS) begin
      case (cnt)
        3'd0:    begin ma = 18'(ent.ny); mb = 18'(t1[2]); end
        3'd1:    begin ma = 18'(ent.nz); mb = 18'(t1[1]); end
        3'd2:    begin ma = 18'(ent.nz); mb = 18'(t1[0]); end
        3'd3:    begin ma = 18'(ent.nx); mb = 18'(t1[2]); end
        3'd4:    begin ma = 18'(ent.nx); mb = 18'(t1[1]); end
        default: begin ma = 18'(ent.ny); mb = 18'(t1[0]); end
      endcase
    end else begin
      ma = first ? $signed({1'b0, f1}) : $signed({1'b0, f2});
      case (idx)
        2'd0:    begin mb = first ? 18'(t1[0]) : 18'(t2[0]); base = 35'(ent.nx); end
        2'd1:    begin mb = first ? 18'(t1[1]) : 18'(t2[1]); base = 35'(ent.ny); end
        default: begin mb = first ? 18'(t1[2]) : 18'(t2[2]); base = 35'(ent.nz); end
      endcase
    end
    prod = ma * mb;
    if (state == B_CRS && !first) nxt = acc[idx] - prod[34:0];
    else if (first) nxt = base + prod[34:0];
    else nxt = acc[idx] + prod[34:0];
    acc_next[0] = (idx == 2'd0) ? nxt : acc[0];
    acc_next[1] = (idx == 2'd1) ? nxt : acc[1];
    acc_next[2] = (idx == 2'd2) ? nxt : acc[2];
    // t1 direction, sign of nz folded in
    nsum = 18'(ent.nx) * 18'sd2 + 18'(ent.ny);
    if (ent.nz[15]) begin
      av0 = -(35'(ent.nz) <<< 1);
      av1 = -35'(ent.nz);
      av2 = 35'(nsum);
    end else begin
      av0 = 35'(ent.nz) <<< 1;
      av1 = 35'(ent.nz);
      av2 = -35'(nsum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      out_valid  <= 1'b0;
      ureq.start <= 1'b0;
    end else begin
      ureq.start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!empty && head.cmd == CMD_QUERY) begin
            state <= head.nz0 ? B_DONE : B_RD;
          end
        end
        B_RD: begin
          if (cnt == 3'd3) state <= B_GAIN;
        end
        B_GAIN: begin
          ureq.start <= 1'b1;
          state      <= B_T1;
        end
        B_T1: begin
          if (ursp.done) state <= B_CRS;
        end
        B_CRS: begin
          if (cnt == 3'd5) begin
            ureq.start <= 1'b1;
            state      <= B_T2;
          end
        end
        B_T2: begin
          if (ursp.done) state <= ursp.ok ? B_VSUM : B_DONE;
        end
        B_VSUM: begin
          if (cnt == 3'd5) begin
            ureq.start <= 1'b1;
            state      <= B_R;
          end
        end
        B_R: begin
          if (ursp.done) state <= B_DONE;
        end
        B_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end

    case (state)
      B_IDLE: begin
        ent    <= head;
        cnt    <= '0;
        res[0] <= '0;
        res[1] <= '0;
        res[2] <= '0;
        st     <= head.nz0 ? ST_NZ_ZERO : ST_OK;
      end
      B_RD: begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd1) h0 <= rdata;
        if (cnt == 3'd2) hx <= rdata;
        if (cnt == 3'd3) begin
          f1 <= (hx > h0) ? 17'(hx - h0) * 17'(gain) : '0;
          f2 <= (rdata > h0) ? 17'(rdata - h0) * 17'(gain) : '0;
        end
      end
      B_GAIN: begin
        ureq.v0 <= av0;
        ureq.v1 <= av1;
        ureq.v2 <= av2;
      end
      B_T1: begin
        cnt <= '0;
        if (ursp.done) begin
          t1[0] <= ursp.u0;
          t1[1] <= ursp.u1;
          t1[2] <= ursp.u2;
        end
      end
      B_CRS, B_VSUM: begin
        cnt    <= cnt + 3'd1;
        acc[0] <= acc_next[0];
        acc[1] <= acc_next[1];
        acc[2] <= acc_next[2];
        ureq.v0 <= acc_next[0];
        ureq.v1 <= acc_next[1];
        ureq.v2 <= acc_next[2];
      end
      B_T2: begin
        cnt <= '0;
        if (ursp.done) begin
          t2[0] <= ursp.u0;
          t2[1] <= ursp.u1;
          t2[2] <= ursp.u2;
          if (!ursp.ok) st <= ST_DEGEN;
        end
      end
      B_R: begin
        if (ursp.done) begin
          if (ursp.ok) begin
            res[0] <= ursp.u0;
            res[1] <= ursp.u1;
            res[2] <= ursp.u2;
          end else begin
            st <= ST_DEGEN;
          end
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_x      <= res[0];
          out_y      <= res[1];
          out_z      <= res[2];
          out_status <= st;
        end
      end
      default: ;
    endcase
  end

  bmnp_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  `BMNP_ASSERT_IMP(a_flag_zero, clk, rst, out_valid && out_status != ST_OK, out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
  `BMNP_ASSERT_IMP(a_no_bad_status, clk, rst, out_valid, out_status != 2'd3)
  `BMNP_ASSERT_IMP(a_pop_idle, clk, rst, pop, state == B_IDLE)
  `BMNP_ASSERT_NXT(a_zero_nz_fast, clk, rst, pop && head.cmd == CMD_QUERY && head.nz0, state == B_DONE)

endmodule

@@ rtl/bump_map_normal_perturb_core.sv @@
// ---------------------------------------------------------------------------
// bump_map_normal_perturb_core
// Height-map bump mapping: perturbs a Q2.14 normal by texel gradients.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake               | content
//  s_axis   | in  | s_axis_tvalid/tready    | load texel or query normal
//  m_axis   | out | m_axis_tvalid/tready    | perturbed normal and status
//  cfg      | in  | cfg_valid/cfg_ready     | map_width, map_height, bump_gain
//
//  Load beat: a single store write in the back end (one store write port).
//  Query beat: the iterative normalize unit run three times (sum of squares,
//  up to 30 scale steps, up to 32 root steps, three 16-step divides) plus
//  three store reads and twelve products.
//  The front accepts one beat per cycle into a 4-deep queue while the back
//  works, so input stalls only when the queue is full.
//  rst is synchronous; the texel store is not cleared.
//  Output register holds a result until m_axis_tready; the back waits.
// ---------------------------------------------------------------------------
module bump_map_normal_perturb_core #(
  parameter int MAX_WIDTH  = bmnp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmnp_pkg::DEF_MAX_HEIGHT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // texel_x, texel_y, texel_red, normal_x, normal_y, normal_z, coord_u,
  // coord_v, zero pad
  input  logic [111:0] s_axis_tdata,
  // command
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [47:0]  m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [8:0]   cfg_data
);
  import bmnp_pkg::*;

  cfg_t   cfg;
  logic   push, push_ready, pop, empty;
  qent_t  push_ent, head;
  logic [$bits(qent_t)-1:0] head_bits;
  q14_t   ox, oy, oz;
  logic [1:0] ost;

  // registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= RST_MAP_WIDTH;
      cfg.map_height <= RST_MAP_HEIGHT;
      cfg.bump_gain  <= RST_BUMP_GAIN;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  cfg.map_width  <= cfg_data;
        CFG_MAP_HEIGHT: cfg.map_height <= cfg_data;
        CFG_BUMP_GAIN:  cfg.bump_gain  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  bmnp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (s_axis_tuser[0]),
    .in_tx      (s_axis_tdata[7:0]),
    .in_ty      (s_axis_tdata[15:8]),
    .in_red     (s_axis_tdata[23:16]),
    .in_nx      (s_axis_tdata[39:24]),
    .in_ny      (s_axis_tdata[55:40]),
    .in_nz      (s_axis_tdata[71:56]),
    .in_u       (s_axis_tdata[89:72]),
    .in_v       (s_axis_tdata[107:90]),
    .push       (push),
    .push_ready (push_ready),
    .push_ent   (push_ent)
  );

  bmnp_fifo #(
    .WIDTH ($bits(qent_t)),
    .DEPTH (4)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_ent),
    .pop        (pop),
    .empty      (empty),
    .head       (head_bits)
  );

  assign head = head_bits;

  bmnp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .gain       (cfg.bump_gain),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_x      (ox),
    .out_y      (oy),
    .out_z      (oz),
    .out_status (ost)
  );

  assign m_axis_tdata = {oz, oy, ox};
  assign m_axis_tuser = ost;

endmodule

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb: bump map normal perturbation core
// Streams texel loads and normal queries through the core, predicts every
// perturbed normal with an in-bench fixed-point model and checks each beat.
// ---------------------------------------------------------------------------
module tb;
  import bmnp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef longint trip_t[3];

  typedef struct {
    logic               cmd;
    logic [7:0]         tx;
    logic [7:0]         ty;
    logic [7:0]         red;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic signed [17:0] u;
    logic signed [17:0] v;
  } beat_t;

  typedef struct {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic [1:0]         st;
  } normal_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic [0:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [8:0]   cfg_data = '0;

  bump_map_normal_perturb_core u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pending beats, expected normals, and the bench's own copy of the core state
  beat_t      pend_q[$];
  normal_t    normal_q[$];
  beat_t      cur;
  logic [7:0] height_mem[65536];
  bit         loaded[65536];
  int         map_w = RST_MAP_WIDTH;
  int         map_h = RST_MAP_HEIGHT;
  int         gain  = RST_BUMP_GAIN;
  bit         quiet = 1'b0;
  int         errors = 0;
  int         n_loads = 0, n_queries = 0, n_flagged = 0, n_checked = 0;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned root64(input longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale to unit length in Q2.14, round half away from zero; 0 on zero length
  function automatic bit unitize3(input trip_t v, output trip_t u);
    longint unsigned s, len, num, q, a;
    int m;
    s = 0;
    m = 0;
    u = '{0, 0, 0};
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? -v[i] : v[i];
      s += a * a;
    end
    if (s == 0) return 1'b0;
    while (s < (64'd1 << 60)) begin
      s <<= 2;
      m++;
    end
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? -v[i] : v[i];
      num = a << (14 + m);
      q = (2 * num + len) / (2 * len);
      if (q > 32768) q = 32768;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      if (u[i] > 32767) u[i] = 32767;
    end
    return 1'b1;
  endfunction

  function automatic int clamp_size(input int s);
    return (s < 1) ? 1 : (s > 256 ? 256 : s);
  endfunction

  // texel index from a Q2.16 coordinate
  function automatic int texel_at(input logic signed [17:0] c, input int size);
    longint p;
    p = longint'(c) * size;
    if (p < 0) return 0;
    p = p >>> 16;
    return (p > size - 1) ? size - 1 : int'(p);
  endfunction

  // addresses a query reads: base, right neighbor, lower neighbor
  function automatic void query_addrs(input beat_t b, output int a0, a1, a2);
    int w, h, x, y;
    w = clamp_size(map_w);
    h = clamp_size(map_h);
    x = texel_at(b.u, w);
    y = texel_at(b.v, h);
    a0 = y * 256 + x;
    a1 = y * 256 + ((x + 1 < w) ? x + 1 : w - 1);
    a2 = ((y + 1 < h) ? y + 1 : h - 1) * 256 + x;
  endfunction

  function automatic normal_t perturb(input beat_t b);
    normal_t r;
    trip_t n, a, t1, c, t2, v, o;
    longint sg, f1, f2;
    int a0, a1, a2;
    r = '{0, 0, 0, ST_OK};
    n = '{b.nx, b.ny, b.nz};
    if (n[2] == 0) begin
      r.st = ST_NZ_ZERO;
      return r;
    end
    sg = (n[2] < 0) ? -1 : 1;
    query_addrs(b, a0, a1, a2);
    f1 = (height_mem[a1] > height_mem[a0]) ? (height_mem[a1] - height_mem[a0]) * gain : 0;
    f2 = (height_mem[a2] > height_mem[a0]) ? (height_mem[a2] - height_mem[a0]) * gain : 0;
    a = '{sg * 2 * n[2], sg * n[2], sg * (-2 * n[0] - n[1])};
    void'(unitize3(a, t1));
    c = '{n[1] * t1[2] - n[2] * t1[1], n[2] * t1[0] - n[0] * t1[2],
          n[0] * t1[1] - n[1] * t1[0]};
    if (!unitize3(c, t2)) begin
      r.st = ST_DEGEN;
      return r;
    end
    for (int i = 0; i < 3; i++) v[i] = n[i] + f1 * t1[i] + f2 * t2[i];
    if (!unitize3(v, o)) begin
      r.st = ST_DEGEN;
      return r;
    end
    r.ox = o[0];
    r.oy = o[1];
    r.oz = o[2];
    return r;
  endfunction

  // driver: one pending beat on the slave side, random idle bursts
  int src_idle = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        if (cur.cmd == CMD_LOAD) begin
          height_mem[{cur.ty, cur.tx}] = cur.red;
          n_loads++;
        end else begin
          normal_q.push_back(perturb(cur));
          n_queries++;
        end
      end
      if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur = pend_q.pop_front();
        s_axis_tdata  <= {4'd0, cur.v, cur.u, cur.nz, cur.ny, cur.nx, cur.red, cur.ty, cur.tx};
        s_axis_tuser  <= cur.cmd;
        s_axis_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) src_idle = $urandom_range(1, 19);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: random stalls on the master side, checks each result beat
  int sink_stall = 0;
  always @(posedge clk) begin
    normal_t e;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (normal_q.size() == 0) begin
          report($sformatf("unexpected result beat %h/%0d", m_axis_tdata, m_axis_tuser));
        end else begin
          e = normal_q.pop_front();
          n_checked++;
          if (e.st != ST_OK) n_flagged++;
          if (m_axis_tdata[15:0] !== e.ox)
            report($sformatf("out_x %h exp %h", m_axis_tdata[15:0], e.ox));
          if (m_axis_tdata[31:16] !== e.oy)
            report($sformatf("out_y %h exp %h", m_axis_tdata[31:16], e.oy));
          if (m_axis_tdata[47:32] !== e.oz)
            report($sformatf("out_z %h exp %h", m_axis_tdata[47:32], e.oz));
          if (m_axis_tuser !== e.st)
            report($sformatf("status %0d exp %0d", m_axis_tuser, e.st));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) sink_stall = $urandom_range(1, 19);
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:  map_w = val;
      CFG_MAP_HEIGHT: map_h = val;
      CFG_BUMP_GAIN:  gain  = val[7:0];
      default: ;
    endcase
  endtask

  // block until the core has drained; loads leave no result, so linger a bit
  task automatic drain();
    while (pend_q.size() > 0 || s_axis_tvalid || normal_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push_load(input int x, input int y, input int red);
    beat_t b;
    b = '{default: '0};
    b.cmd = CMD_LOAD;
    b.tx = x;
    b.ty = y;
    b.red = red;
    b.nx = $urandom;
    b.u = $urandom;
    pend_q.push_back(b);
    loaded[y * 256 + x] = 1'b1;
  endtask

  // any texel the query would read that was never loaded gets loaded first
  task automatic push_query(input int nx, ny, nz, u, v);
    beat_t b;
    int a[3];
    b = '{default: '0};
    b.cmd = CMD_QUERY;
    b.nx = nx;
    b.ny = ny;
    b.nz = nz;
    b.u = u;
    b.v = v;
    b.tx = $urandom;
    b.red = $urandom;
    query_addrs(b, a[0], a[1], a[2]);
    foreach (a[i])
      if (!loaded[a[i]]) push_load(a[i] % 256, a[i] / 256, $urandom_range(0, 255));
    pend_q.push_back(b);
  endtask

  task automatic random_items(input int count);
    int u, v;
    repeat (count) begin
      if ($urandom_range(0, 9) < 4) begin
        push_load($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        // mostly inside the map, sometimes anywhere in Q2.16
        u = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535);
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535);
        push_query($urandom, $urandom, ($urandom_range(0, 15) == 0) ? 0 : $urandom, u, v);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: extreme texels and heights, zero nz, extreme normals and coords
    push_load(0, 0, 0);
    push_load(1, 0, 255);
    push_load(0, 1, 255);
    push_load(255, 255, 255);
    push_load(254, 255, 0);
    push_load(255, 254, 0);
    push_query(0, 0, 16384, 0, 0);
    push_query(0, 0, 0, 0, 0);
    push_query(32767, 32767, 32767, 0, 0);
    push_query(-32768, -32768, -32768, 0, 0);
    push_query(1000, -2000, -32768, 131071, 131071);
    push_query(0, 0, 1, -131072, -131072);
    push_query(0, 0, -1, 65535, 65535);
    push_query(32767, -32768, 1, 65536, 0);
    push_query(-5, 7, 3, 0, 131071);
    drain();

    // tiny map with no gain, then largest map with full gain
    cfg_write(CFG_MAP_WIDTH, 9'd1);
    cfg_write(CFG_MAP_HEIGHT, 9'd1);
    cfg_write(CFG_BUMP_GAIN, 9'd0);
    push_query(12345, -321, 9999, 131071, 131071);
    random_items(160);
    drain();

    cfg_write(CFG_MAP_WIDTH, 9'd256);
    cfg_write(CFG_MAP_HEIGHT, 9'd256);
    cfg_write(CFG_BUMP_GAIN, 9'd255);
    push_query(100, 200, 300, 65535, 0);
    random_items(160);
    drain();

    // out-of-range sizes clamp to the map limits
    cfg_write(CFG_MAP_WIDTH, 9'd511);
    cfg_write(CFG_MAP_HEIGHT, 9'd0);
    cfg_write(CFG_BUMP_GAIN, 9'h1FF);
    random_items(160);
    drain();

    cfg_write(CFG_MAP_WIDTH, $urandom_range(2, 255));
    cfg_write(CFG_MAP_HEIGHT, $urandom_range(2, 255));
    cfg_write(CFG_BUMP_GAIN, $urandom_range(1, 254));
    random_items(160);
    drain();

    cfg_write(CFG_MAP_WIDTH, $urandom_range(1, 16));
    cfg_write(CFG_MAP_HEIGHT, $urandom_range(200, 511));
    cfg_write(CFG_BUMP_GAIN, $urandom_range(0, 511));
    random_items(160);
    drain();

    // last stretch at full rate on both sides
    quiet = 1'b1;
    random_items(160);
    drain();

    $display("covered %0d texel loads and %0d normal queries over six register settings",
             n_loads, n_queries);
    $display("checked %0d result beats, %0d of them flagged", n_checked, n_flagged);
    if (errors == 0 && normal_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", normal_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bmnp_pkg.sv
rtl/bmnp_front.sv
rtl/bmnp_fifo.sv
rtl/bmnp_unit.sv
rtl/bmnp_back.sv
rtl/bump_map_normal_perturb_core.sv
verif/tb.sv
